// ----- sv/fpb_pkg.sv -----
// Shared types and constants for the framebuffer pixel blend unit.
package fpb_pkg;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 56;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 11;
    localparam int INDEX_W = 20;

    localparam logic [CFG_ADDR_W-1:0] CFG_ACTIVE_WIDTH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACTIVE_HEIGHT = 2'd1;

    localparam logic [CFG_DATA_W-1:0] ACTIVE_SIZE_RST = 11'd1024;
    localparam logic [31:0] RGB_MASK = 32'h00FF_FFFF;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR = 8'h00;

    typedef enum logic [1:0] {
        OP_RAW    = 2'd0,
        OP_BLEND  = 2'd1,
        OP_INVERT = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] color;
        logic [7:0]  alpha;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_WB
    } back_state_t;

endpackage

// ----- sv/fpb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fpb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/fpb_queue.sv -----
// Small register FIFO between the classify front and the pixel back end.
module fpb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             not_empty
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full = (count_reg == (PW + 1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_data = slot_reg[rd_ptr_reg];

endmodule

// ----- sv/fpb_front.sv -----
// Front end: configuration registers, bounds check and operation classify.
module fpb_front #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HEIGHT = 1024,
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [fpb_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [fpb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_operation,
    input  logic signed [15:0]              s_pos_x,
    input  logic signed [15:0]              s_pos_y,
    input  logic [31:0]                     s_raw_color,
    input  logic [7:0]                      s_src_red,
    input  logic [7:0]                      s_src_green,
    input  logic [7:0]                      s_src_blue,
    input  logic [7:0]                      s_src_alpha,
    input  logic                            clear_busy,
    input  logic                            q_full,
    output logic                            q_push,
    output logic [AW-1:0]                   q_addr,
    output fpb_pkg::cmd_t                   q_cmd
);

    logic [fpb_pkg::CFG_DATA_W-1:0] width_reg, width_next;
    logic [fpb_pkg::CFG_DATA_W-1:0] height_reg, height_next;
    logic [15:0]   x_abs, y_abs;
    logic          x_ok, y_ok;
    logic          keep;
    fpb_pkg::op_t  op_in;
    logic [31:0]   rgb_word;

    always_comb begin
        width_next = width_reg;
        height_next = height_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                fpb_pkg::CFG_ACTIVE_WIDTH: width_next = cfg_wdata;
                fpb_pkg::CFG_ACTIVE_HEIGHT: height_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= fpb_pkg::ACTIVE_SIZE_RST;
            height_reg <= fpb_pkg::ACTIVE_SIZE_RST;
        end else begin
            width_reg <= width_next;
            height_reg <= height_next;
        end
    end

    always_comb begin
        x_abs = {1'b0, s_pos_x[14:0]};
        y_abs = {1'b0, s_pos_y[14:0]};
        x_ok = !s_pos_x[15] && (x_abs < {5'b0, width_reg}) && (x_abs < 16'(MAX_WIDTH));
        y_ok = !s_pos_y[15] && (y_abs < {5'b0, height_reg}) && (y_abs < 16'(MAX_HEIGHT));
        q_addr = AW'(32'(y_abs) * 32'(MAX_WIDTH) + 32'(x_abs));
        op_in = fpb_pkg::op_t'(s_operation);
        rgb_word = {8'h00, s_src_red, s_src_green, s_src_blue};

        keep = 1'b0;
        q_cmd.op = fpb_pkg::OP_RAW;
        q_cmd.color = s_raw_color;
        q_cmd.alpha = s_src_alpha;
        case (op_in)
            fpb_pkg::OP_RAW: begin
                keep = 1'b1;
            end
            fpb_pkg::OP_BLEND: begin
                q_cmd.color = rgb_word;
                if (s_src_alpha == fpb_pkg::ALPHA_OPAQUE) begin
                    keep = 1'b1;
                end else if (s_src_alpha != fpb_pkg::ALPHA_CLEAR) begin
                    keep = 1'b1;
                    q_cmd.op = fpb_pkg::OP_BLEND;
                end
            end
            fpb_pkg::OP_INVERT: begin
                keep = 1'b1;
                q_cmd.op = fpb_pkg::OP_INVERT;
            end
            default: keep = 1'b0;
        endcase
    end

    assign s_ready = !clear_busy && !q_full;
    assign q_push = s_valid && s_ready && keep && x_ok && y_ok;

endmodule

// ----- sv/fpb_back.sv -----
// Back end: frame store clear, read-modify-write and result register.
module fpb_back #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HEIGHT = 1024,
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_not_empty,
    input  logic [AW-1:0]                q_addr,
    input  fpb_pkg::cmd_t                q_cmd,
    output logic                         q_pop,
    output logic                         clear_busy,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [fpb_pkg::INDEX_W-1:0]  m_index,
    output logic [31:0]                  m_value
);

    fpb_pkg::back_state_t state_reg, state_next;
    logic [AW-1:0]        clr_addr_reg, clr_addr_next;
    logic                 m_valid_reg, m_valid_next;
    logic [fpb_pkg::INDEX_W-1:0] m_index_reg;
    logic [31:0]          m_value_reg;
    logic [AW-1:0]        addr_reg;
    fpb_pkg::cmd_t        cmd_reg;
    logic [31:0]          old_reg;
    logic [15:0]          prod_src_reg [3];
    logic [15:0]          prod_dst_reg [3];

    logic                 wr_en, rd_en, load_out;
    logic [AW-1:0]        wr_addr;
    logic [31:0]          wr_data, rd_data, new_val;
    logic [16:0]          mix_sum [3];
    logic [16:0]          mix_quo [3];
    logic [7:0]           inv_alpha;

    fpb_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_frame_ram (
        .aclk(aclk),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en(rd_en),
        .rd_addr(q_addr),
        .rd_data(rd_data)
    );

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            mix_sum[c] = 17'(prod_src_reg[c]) + 17'(prod_dst_reg[c]);
            mix_quo[c] = (mix_sum[c] + 17'd1 + (mix_sum[c] >> 8)) >> 8;
        end
        case (cmd_reg.op)
            fpb_pkg::OP_BLEND:
                new_val = {8'h00, mix_quo[2][7:0], mix_quo[1][7:0], mix_quo[0][7:0]};
            fpb_pkg::OP_INVERT: new_val = old_reg ^ fpb_pkg::RGB_MASK;
            default: new_val = cmd_reg.color;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        clr_addr_next = clr_addr_reg;
        q_pop = 1'b0;
        rd_en = 1'b0;
        wr_en = 1'b0;
        wr_addr = clr_addr_reg;
        wr_data = '0;
        load_out = 1'b0;
        case (state_reg)
            fpb_pkg::ST_CLEAR: begin
                wr_en = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    state_next = fpb_pkg::ST_IDLE;
                end
            end
            fpb_pkg::ST_IDLE: begin
                if (q_not_empty) begin
                    q_pop = 1'b1;
                    rd_en = 1'b1;
                    state_next = fpb_pkg::ST_MUL;
                end
            end
            fpb_pkg::ST_MUL: begin
                state_next = fpb_pkg::ST_WB;
            end
            fpb_pkg::ST_WB: begin
                if (!m_valid_reg || m_ready) begin
                    wr_en = 1'b1;
                    wr_addr = addr_reg;
                    wr_data = new_val;
                    load_out = 1'b1;
                    state_next = fpb_pkg::ST_IDLE;
                end
            end
            default: state_next = fpb_pkg::ST_IDLE;
        endcase
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fpb_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign inv_alpha = 8'hFF - cmd_reg.alpha;

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            addr_reg <= q_addr;
            cmd_reg <= q_cmd;
        end
        if (state_reg == fpb_pkg::ST_MUL) begin
            old_reg <= rd_data;
            for (int c = 0; c < 3; c++) begin
                prod_src_reg[c] <= 16'(cmd_reg.color[8*c +: 8]) * 16'(cmd_reg.alpha);
                prod_dst_reg[c] <= 16'(rd_data[8*c +: 8]) * 16'(inv_alpha);
            end
        end
        if (load_out) begin
            m_index_reg <= fpb_pkg::INDEX_W'(addr_reg);
            m_value_reg <= new_val;
        end
    end

    assign clear_busy = (state_reg == fpb_pkg::ST_CLEAR);
    assign m_valid = m_valid_reg;
    assign m_index = m_index_reg;
    assign m_value = m_value_reg;

endmodule

// ----- sv/framebuffer_pixel_blend_unit.sv -----
// Top level of the framebuffer pixel blend unit.
//
//   channel | direction | tdata fields, low bit up
//   s_axis  | in        | operation, pos_x, pos_y, raw_color, src_red, src_green,
//           |           | src_blue, src_alpha
//   m_axis  | out       | pixel_index, pixel_value
//   cfg     | in        | index 0 active_width, index 1 active_height
//
// Each stored pixel passes through the back-end steps read issue, multiply and
// write back on the single frame RAM; a new pixel starts only after write back.
// After reset the frame RAM is swept to zero with s_axis_tready low. Dropped items
// are accepted like any other item but queue nothing. A stalled m_axis holds the
// back end in write back; the 2-entry queue keeps accepting until it is full.
module framebuffer_pixel_blend_unit #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [fpb_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [fpb_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // operation[1:0], pos_x[17:2], pos_y[33:18], raw_color[65:34], src_red[73:66],
    // src_green[81:74], src_blue[89:82], src_alpha[97:90], zero pad
    input  logic [fpb_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // pixel_index[19:0], pixel_value[51:20], zero pad
    output logic [fpb_pkg::M_TDATA_W-1:0]       m_axis_tdata
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QW = AW + $bits(fpb_pkg::cmd_t);

    logic                         clear_busy, q_full, q_push, q_pop, q_not_empty;
    logic [AW-1:0]                push_addr;
    fpb_pkg::cmd_t                push_cmd, head_cmd;
    logic [QW-1:0]                head_data;
    logic [fpb_pkg::INDEX_W-1:0]  m_index;
    logic [31:0]                  m_value;

    fpb_front #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_front (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_axis_tvalid),
        .s_ready(s_axis_tready),
        .s_operation(s_axis_tdata[1:0]),
        .s_pos_x(s_axis_tdata[17:2]),
        .s_pos_y(s_axis_tdata[33:18]),
        .s_raw_color(s_axis_tdata[65:34]),
        .s_src_red(s_axis_tdata[73:66]),
        .s_src_green(s_axis_tdata[81:74]),
        .s_src_blue(s_axis_tdata[89:82]),
        .s_src_alpha(s_axis_tdata[97:90]),
        .clear_busy(clear_busy),
        .q_full(q_full),
        .q_push(q_push),
        .q_addr(push_addr),
        .q_cmd(push_cmd)
    );

    fpb_queue #(
        .WIDTH(QW),
        .DEPTH(2)
    ) u_queue (
        .aclk(aclk),
        .aresetn(aresetn),
        .push(q_push),
        .push_data({push_addr, push_cmd}),
        .full(q_full),
        .pop(q_pop),
        .head_data(head_data),
        .not_empty(q_not_empty)
    );

    assign head_cmd = fpb_pkg::cmd_t'(head_data[$bits(fpb_pkg::cmd_t)-1:0]);

    fpb_back #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_back (
        .aclk(aclk),
        .aresetn(aresetn),
        .q_not_empty(q_not_empty),
        .q_addr(head_data[QW-1 -: AW]),
        .q_cmd(head_cmd),
        .q_pop(q_pop),
        .clear_busy(clear_busy),
        .m_valid(m_axis_tvalid),
        .m_ready(m_axis_tready),
        .m_index(m_index),
        .m_value(m_value)
    );

    assign m_axis_tdata = {4'b0, m_value, m_index};

endmodule
